FILE: src/buddy_page_allocator_macros.svh
// Assertion macros for the buddy page allocator.
// Used by the RTL files that assert; define NO_ASSERTIONS to drop them.
`ifndef BUDDY_PAGE_ALLOCATOR_MACROS_SVH
`define BUDDY_PAGE_ALLOCATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
// Plain implication checked at every clock edge outside reset.
`define BPA_ASSERT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("bpa assertion failed");
// Consequence checked in the cycle after the antecedent.
`define BPA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("bpa assertion failed");
`else
`define BPA_ASSERT(lbl, clk, rstn, ante, cons)
`define BPA_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: src/bpa_pkg.sv
// Shared constants, types and helper functions of the buddy page allocator.
// No dependencies; imported by the page memory, the top level, the checker and the testbench.
`default_nettype none
package bpa_pkg;
    localparam int PAGES  = 16384;
    localparam int PAGE_W = 14;
    localparam int LINK_W = 15;
    localparam int ORDERS = 11;
    localparam int ORD_W  = 4;
    localparam int CNT_W  = 15;

    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(PAGES);
    localparam logic [ORD_W-1:0]  TOP_ORDER = ORD_W'(ORDERS - 1);

    localparam logic [1:0] FUNC_ADD   = 2'd0;
    localparam logic [1:0] FUNC_ALLOC = 2'd1;
    localparam logic [1:0] FUNC_FREE  = 2'd2;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_NONE = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    // One page entry of the page memory.
    typedef struct packed {
        logic              flag;
        logic [ORD_W-1:0]  order;
        logic [LINK_W-1:0] next;
        logic [LINK_W-1:0] prev;
    } t_page_ent;

    // Write request with one enable per field.
    typedef struct packed {
        logic              wr_flag;
        logic              wr_order;
        logic              wr_next;
        logic              wr_prev;
        logic [PAGE_W-1:0] addr;
        t_page_ent         data;
    } t_mem_wr;

    // Smallest order whose block holds n pages.
    function automatic logic [4:0] ceil_order(input logic [CNT_W-1:0] n);
        logic [CNT_W-1:0] m;
        logic [4:0]       o;
        m = n - 1'b1;
        o = '0;
        for (int k = 0; k < CNT_W; k++) begin
            if (m[k]) o = 5'(k + 1);
        end
        if (n <= CNT_W'(1)) o = '0;
        return o;
    endfunction

    // Position of the highest set bit.
    function automatic logic [ORD_W-1:0] floor_log2(input logic [CNT_W-1:0] n);
        logic [ORD_W-1:0] o;
        o = '0;
        for (int k = 0; k < CNT_W; k++) begin
            if (n[k]) o = ORD_W'(k);
        end
        return o;
    endfunction
endpackage
`default_nettype wire

FILE: src/bpa_page_mem.sv
// Page memory: free flag, order and list links for every page.
// Field write enables, one registered read port. Uses bpa_pkg.
`default_nettype none
module bpa_page_mem
    import bpa_pkg::*;
(
    input  wire logic              i_clk,
    input  wire t_mem_wr           i_wr,
    input  wire logic              i_rd_en,
    input  wire logic [PAGE_W-1:0] i_rd_addr,
    output t_page_ent              o_rd_data
);
    logic              mem_flag  [PAGES];
    logic [ORD_W-1:0]  mem_order [PAGES];
    logic [LINK_W-1:0] mem_next  [PAGES];
    logic [LINK_W-1:0] mem_prev  [PAGES];
    t_page_ent         r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.wr_flag)  mem_flag[i_wr.addr]  <= i_wr.data.flag;
        if (i_wr.wr_order) mem_order[i_wr.addr] <= i_wr.data.order;
        if (i_wr.wr_next)  mem_next[i_wr.addr]  <= i_wr.data.next;
        if (i_wr.wr_prev)  mem_prev[i_wr.addr]  <= i_wr.data.prev;
        if (i_rd_en) begin
            r_rd_data.flag  <= mem_flag[i_rd_addr];
            r_rd_data.order <= mem_order[i_rd_addr];
            r_rd_data.next  <= mem_next[i_rd_addr];
            r_rd_data.prev  <= mem_prev[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule
`default_nettype wire

FILE: src/buddy_page_allocator.sv
// Buddy page allocator top level: sequencer, free list heads and counters.
// Uses bpa_pkg, bpa_page_mem and the assertion macros header.
//
//  channel   signals                                        direction
//  input     i_in_valid/o_in_ready, func, index, count       in
//  result    o_out_valid/i_out_ready, status, index, avail   out
//  config    i_cfg_we, i_cfg_data (total_pages)              in
//
// After reset a clearing pass writes every free flag to zero, one page per
// cycle, while no input transfer is taken.
// A rejected request goes straight to the response step; an add pushes one
// block at a time, an allocate unlinks a block and splits it one order at a
// time (dropping an upper half past the end), and a free merges step by step.
// The steps are serialised by the single write port of the page memory.
// A finished result sits in an output register, so the next input transfer
// is taken while it waits; the last step of an item stalls only if the
// previous result has not yet been taken.
`default_nettype none
`include "buddy_page_allocator_macros.svh"
module buddy_page_allocator
    import bpa_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [1:0]        i_func,
    input  wire logic [PAGE_W-1:0] i_page_index,
    input  wire logic [CNT_W-1:0]  i_page_count,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [1:0]             o_status,
    output logic [PAGE_W-1:0]      o_page_index_res,
    output logic [CNT_W-1:0]       o_pages_avail,
    input  wire logic              i_cfg_we,
    input  wire logic [CNT_W-1:0]  i_cfg_data
);
    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DISPATCH, S_ADD, S_ALLOC_RD, S_UL_NEXT, S_UL_PREV,
        S_UL_FLAG, S_SPLIT, S_PUSH_HEAD, S_PUSH_LINK, S_FREE_CHECK, S_FREE_TEST,
        S_FREE_NEXT, S_RESP
    } t_state;

    t_state            r_state, r_ret;
    logic [1:0]        r_func;
    logic [PAGE_W-1:0] r_base, r_p, r_pg, r_ul_pg, r_push_pg, r_b, r_clr_addr;
    logic [CNT_W-1:0]  r_n, r_rest;
    logic [ORD_W-1:0]  r_ord_req, r_ord_cur, r_ul_ord, r_push_ord;
    logic [LINK_W-1:0] r_h;
    logic [LINK_W-1:0] r_head [ORDERS];
    logic [CNT_W-1:0]  r_count [ORDERS];
    logic [CNT_W-1:0]  r_free_total, r_total_pages;
    logic [1:0]        r_status;
    logic [PAGE_W-1:0] r_res;
    logic              r_out_valid;
    logic [1:0]        r_out_status;
    logic [PAGE_W-1:0] r_out_index;
    logic [CNT_W-1:0]  r_out_free;

    t_mem_wr           mem_wr;
    logic              rd_en;
    logic [PAGE_W-1:0] rd_addr;
    t_page_ent         rd_data;

    // Decode helpers.
    logic [4:0]        req_order;
    logic [PAGE_W+1:0] add_end;
    logic              found;
    logic [ORD_W-1:0]  found_ord;
    logic [ORD_W-1:0]  add_ord;
    logic [PAGE_W-1:0] buddy;
    logic [LINK_W-1:0] half;
    logic [ORD_W-1:0]  split_ord;

    bpa_page_mem u_mem (
        .i_clk     (i_clk),
        .i_wr      (mem_wr),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        req_order = ceil_order(r_n);
        add_end   = {2'b00, r_base} + {1'b0, r_n};
        found     = 1'b0;
        found_ord = '0;
        for (int k = ORDERS - 1; k >= 0; k--) begin
            if (ORD_W'(k) >= req_order[ORD_W-1:0] && !r_head[k][PAGE_W]) begin
                found     = 1'b1;
                found_ord = ORD_W'(k);
            end
        end
        add_ord   = (floor_log2(r_rest) > TOP_ORDER) ? TOP_ORDER : floor_log2(r_rest);
        buddy     = r_p ^ (PAGE_W'(1) << r_ord_cur);
        split_ord = r_ord_cur - 1'b1;
        half      = {1'b0, r_pg} + (LINK_W'(1) << split_ord);
    end

    // Page memory accesses: at most one write or one read per cycle.
    always_comb begin
        mem_wr  = '0;
        rd_en   = 1'b0;
        rd_addr = r_ul_pg;
        unique case (r_state)
            S_CLEAR: begin
                mem_wr.wr_flag = 1'b1;
                mem_wr.addr    = r_clr_addr;
            end
            S_ALLOC_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_ul_pg;
            end
            S_UL_NEXT: begin
                mem_wr.wr_next   = !rd_data.prev[PAGE_W];
                mem_wr.addr      = rd_data.prev[PAGE_W-1:0];
                mem_wr.data.next = rd_data.next;
            end
            S_UL_PREV: begin
                mem_wr.wr_prev   = !rd_data.next[PAGE_W];
                mem_wr.addr      = rd_data.next[PAGE_W-1:0];
                mem_wr.data.prev = rd_data.prev;
            end
            S_UL_FLAG: begin
                mem_wr.wr_flag = 1'b1;
                mem_wr.addr    = r_ul_pg;
            end
            S_PUSH_HEAD: begin
                mem_wr.wr_flag    = 1'b1;
                mem_wr.wr_order   = 1'b1;
                mem_wr.wr_next    = 1'b1;
                mem_wr.wr_prev    = 1'b1;
                mem_wr.addr       = r_push_pg;
                mem_wr.data.flag  = 1'b1;
                mem_wr.data.order = r_push_ord;
                mem_wr.data.next  = r_head[r_push_ord];
                mem_wr.data.prev  = NULL_LINK;
            end
            S_PUSH_LINK: begin
                mem_wr.wr_prev   = !r_h[PAGE_W];
                mem_wr.addr      = r_h[PAGE_W-1:0];
                mem_wr.data.prev = {1'b0, r_push_pg};
            end
            S_FREE_CHECK: begin
                rd_en   = (r_ord_cur != TOP_ORDER) && ({1'b0, buddy} < r_total_pages);
                rd_addr = buddy;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr_addr    <= '0;
            r_out_valid   <= 1'b0;
            r_free_total  <= '0;
            r_total_pages <= CNT_W'(PAGES);
            for (int k = 0; k < ORDERS; k++) begin
                r_head[k]  <= NULL_LINK;
                r_count[k] <= '0;
            end
        end else begin
            if (i_cfg_we) r_total_pages <= i_cfg_data;
            // The result register fills in the response step and empties on a transfer.
            if (r_state == S_RESP && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (&r_clr_addr) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_func  <= i_func;
                        r_base  <= i_page_index;
                        r_n     <= i_page_count;
                        r_state <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    r_res <= '0;
                    if (r_n == '0) begin
                        r_status <= ST_BAD;
                        r_state  <= S_RESP;
                    end else begin
                        case (r_func)
                            FUNC_ADD: begin
                                if (add_end > (PAGE_W+2)'(PAGES)) begin
                                    r_status <= ST_BAD;
                                    r_state  <= S_RESP;
                                end else begin
                                    r_status <= ST_DONE;
                                    r_p      <= r_base;
                                    r_rest   <= r_n;
                                    r_state  <= S_ADD;
                                end
                            end
                            FUNC_ALLOC: begin
                                if (req_order >= 5'(ORDERS)) begin
                                    r_status <= ST_BAD;
                                    r_state  <= S_RESP;
                                end else if (!found) begin
                                    r_status <= ST_NONE;
                                    r_state  <= S_RESP;
                                end else begin
                                    r_status  <= ST_DONE;
                                    r_pg      <= r_head[found_ord][PAGE_W-1:0];
                                    r_ul_pg   <= r_head[found_ord][PAGE_W-1:0];
                                    r_ul_ord  <= found_ord;
                                    r_ord_cur <= found_ord;
                                    r_ord_req <= req_order[ORD_W-1:0];
                                    r_ret     <= S_SPLIT;
                                    r_state   <= S_ALLOC_RD;
                                end
                            end
                            FUNC_FREE: begin
                                if (req_order >= 5'(ORDERS)) begin
                                    r_status <= ST_BAD;
                                    r_state  <= S_RESP;
                                end else begin
                                    r_status  <= ST_DONE;
                                    r_p       <= r_base;
                                    r_ord_cur <= req_order[ORD_W-1:0];
                                    r_state   <= S_FREE_CHECK;
                                end
                            end
                            default: begin
                                r_status <= ST_BAD;
                                r_state  <= S_RESP;
                            end
                        endcase
                    end
                end
                S_ADD: begin
                    if (r_rest == '0) begin
                        r_state <= S_RESP;
                    end else begin
                        r_push_pg  <= r_p;
                        r_push_ord <= add_ord;
                        r_p        <= r_p + (PAGE_W'(1) << add_ord);
                        r_rest     <= r_rest - (CNT_W'(1) << add_ord);
                        r_ret      <= S_ADD;
                        r_state    <= S_PUSH_HEAD;
                    end
                end
                S_ALLOC_RD: r_state <= S_UL_NEXT;
                S_UL_NEXT: begin
                    // With no predecessor the block must be the list head.
                    if (rd_data.prev[PAGE_W] && r_head[r_ul_ord] == {1'b0, r_ul_pg})
                        r_head[r_ul_ord] <= rd_data.next;
                    r_state <= S_UL_PREV;
                end
                S_UL_PREV: r_state <= S_UL_FLAG;
                S_UL_FLAG: begin
                    r_count[r_ul_ord] <= r_count[r_ul_ord] - 1'b1;
                    r_free_total      <= r_free_total - (CNT_W'(1) << r_ul_ord);
                    r_state           <= r_ret;
                end
                S_SPLIT: begin
                    if (r_ord_cur > r_ord_req) begin
                        r_ord_cur <= split_ord;
                        // An upper half past the end of memory is dropped.
                        if (!half[PAGE_W]) begin
                            r_push_pg  <= half[PAGE_W-1:0];
                            r_push_ord <= split_ord;
                            r_ret      <= S_SPLIT;
                            r_state    <= S_PUSH_HEAD;
                        end
                    end else begin
                        r_res   <= r_pg;
                        r_state <= S_RESP;
                    end
                end
                S_PUSH_HEAD: begin
                    r_h                  <= r_head[r_push_ord];
                    r_head[r_push_ord]   <= {1'b0, r_push_pg};
                    r_count[r_push_ord]  <= r_count[r_push_ord] + 1'b1;
                    r_free_total         <= r_free_total + (CNT_W'(1) << r_push_ord);
                    r_state              <= S_PUSH_LINK;
                end
                S_PUSH_LINK: r_state <= r_ret;
                S_FREE_CHECK: begin
                    r_b <= buddy;
                    if (r_ord_cur == TOP_ORDER || {1'b0, buddy} >= r_total_pages) begin
                        r_push_pg  <= r_p;
                        r_push_ord <= r_ord_cur;
                        r_ret      <= S_RESP;
                        r_state    <= S_PUSH_HEAD;
                    end else begin
                        r_state <= S_FREE_TEST;
                    end
                end
                S_FREE_TEST: begin
                    if (rd_data.flag && rd_data.order == r_ord_cur) begin
                        r_ul_pg  <= r_b;
                        r_ul_ord <= r_ord_cur;
                        r_ret    <= S_FREE_NEXT;
                        r_state  <= S_UL_NEXT;
                    end else begin
                        r_push_pg  <= r_p;
                        r_push_ord <= r_ord_cur;
                        r_ret      <= S_RESP;
                        r_state    <= S_PUSH_HEAD;
                    end
                end
                S_FREE_NEXT: begin
                    if (r_b < r_p) r_p <= r_b;
                    r_ord_cur <= r_ord_cur + 1'b1;
                    r_state   <= S_FREE_CHECK;
                end
                S_RESP: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_status <= r_status;
                        r_out_index  <= r_res;
                        r_out_free   <= r_free_total;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_page_index_res = r_out_index;
    assign o_pages_avail    = r_out_free;

    // The memory has no forwarding, so a read must never share a cycle with a write.
    `BPA_ASSERT(a_no_rd_wr, i_clk, i_rst_n, rd_en,
        !(mem_wr.wr_flag || mem_wr.wr_order || mem_wr.wr_next || mem_wr.wr_prev))
    `BPA_ASSERT_NEXT(a_accept_dispatch, i_clk, i_rst_n,
        i_in_valid && o_in_ready, r_state == S_DISPATCH)
    `BPA_ASSERT(a_clear_blocks, i_clk, i_rst_n, r_state == S_CLEAR, !o_in_ready)
    `BPA_ASSERT_NEXT(a_unlink_reads, i_clk, i_rst_n, r_state == S_ALLOC_RD,
        r_state == S_UL_NEXT)
endmodule
`default_nettype wire

FILE: tb/sv/bpa_checker.sv
// Result checker for the buddy page allocator: watches the input, result and
// register ports, predicts each result and compares. Depends on bpa_pkg.
module bpa_checker
    import bpa_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_ready,
    input  wire logic [1:0]        i_func,
    input  wire logic [PAGE_W-1:0] i_page_index,
    input  wire logic [CNT_W-1:0]  i_page_count,
    input  wire logic              i_out_valid,
    input  wire logic              i_out_ready,
    input  wire logic [1:0]        i_status,
    input  wire logic [PAGE_W-1:0] i_page_index_res,
    input  wire logic [CNT_W-1:0]  i_pages_avail,
    input  wire logic              i_cfg_we,
    input  wire logic [CNT_W-1:0]  i_cfg_data,
    output int                     o_fail_count,
    output int                     o_pending
);
    typedef struct packed {
        logic [1:0]        status;
        logic [PAGE_W-1:0] page;
        logic [CNT_W-1:0]  pages_avail;
    } t_alloc_result;

    // Shadow copy of the allocator state.
    logic [CNT_W-1:0]  page_limit;
    logic [LINK_W-1:0] head_q [ORDERS];
    logic [CNT_W-1:0]  count_q [ORDERS];
    logic              is_free [PAGES];
    logic [ORD_W-1:0]  blk_ord [PAGES];
    logic [LINK_W-1:0] nxt [PAGES];
    logic [LINK_W-1:0] prv [PAGES];
    logic [CNT_W-1:0]  free_sum;

    t_alloc_result expected_results[$];

    task automatic push_free(input int pg, input int ord);
        logic [LINK_W-1:0] h;
        h = head_q[ord];
        blk_ord[pg] = ORD_W'(ord);
        is_free[pg] = 1'b1;
        nxt[pg] = h;
        prv[pg] = NULL_LINK;
        if (h < PAGES) prv[h] = LINK_W'(pg);
        head_q[ord] = LINK_W'(pg);
        count_q[ord] = count_q[ord] + 1'b1;
        free_sum = free_sum + CNT_W'(1 << ord);
    endtask

    task automatic take_free(input int pg, input int ord);
        logic [LINK_W-1:0] pv, nx;
        pv = prv[pg];
        nx = nxt[pg];
        if (pv < PAGES) nxt[pv] = nx;
        else if (head_q[ord] == pg) head_q[ord] = nx;
        if (nx < PAGES) prv[nx] = pv;
        is_free[pg] = 1'b0;
        count_q[ord] = count_q[ord] - 1'b1;
        free_sum = free_sum - CNT_W'(1 << ord);
    endtask

    function automatic int round_order(input int n);
        int o;
        o = 0;
        while (o < 31 && (1 << o) < n) o++;
        return o;
    endfunction

    // Applies one request to the shadow state and returns its result.
    task automatic predict_allocation(input logic [1:0] fn, input int base, input int n,
                                      output t_alloc_result r);
        int p, rest, ord, i, pg, b;
        r = '0;
        if (n == 0 || !(fn inside {FUNC_ADD, FUNC_ALLOC, FUNC_FREE})) begin
            r.status = ST_BAD;
        end else if (fn == FUNC_ADD) begin
            if (base + n > PAGES) begin
                r.status = ST_BAD;
            end else begin
                p = base;
                rest = n;
                for (i = ORDERS - 1; i >= 0; i--) begin
                    while (rest >= (1 << i)) begin
                        push_free(p, i);
                        p += 1 << i;
                        rest -= 1 << i;
                    end
                end
            end
        end else if (fn == FUNC_ALLOC) begin
            ord = round_order(n);
            if (ord >= ORDERS) begin
                r.status = ST_BAD;
            end else begin
                i = ord;
                while (i < ORDERS && head_q[i] >= PAGES) i++;
                if (i >= ORDERS) begin
                    r.status = ST_NONE;
                end else begin
                    pg = head_q[i];
                    take_free(pg, i);
                    while (i > ord) begin
                        i--;
                        if (pg + (1 << i) < PAGES) push_free(pg + (1 << i), i);
                    end
                    r.page = PAGE_W'(pg);
                end
            end
        end else begin
            ord = round_order(n);
            if (ord >= ORDERS || base >= PAGES) begin
                r.status = ST_BAD;
            end else begin
                p = base;
                // Merge upward while the buddy is a free block of the same size.
                while (ord < ORDERS - 1) begin
                    b = p ^ (1 << ord);
                    if (b >= page_limit || b >= PAGES || !is_free[b] || blk_ord[b] != ord)
                        break;
                    take_free(b, ord);
                    if (b < p) p = b;
                    ord++;
                end
                push_free(p, ord);
            end
        end
        r.pages_avail = free_sum;
    endtask

    always @(posedge i_clk) begin
        t_alloc_result want;
        t_alloc_result got;
        if (!i_rst_n) begin
            page_limit = CNT_W'(PAGES);
            for (int k = 0; k < ORDERS; k++) begin
                head_q[k] = NULL_LINK;
                count_q[k] = '0;
            end
            for (int k = 0; k < PAGES; k++) is_free[k] = 1'b0;
            free_sum = '0;
            expected_results.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) page_limit = i_cfg_data;
            if (i_in_valid && i_in_ready) begin
                predict_allocation(i_func, int'(i_page_index), int'(i_page_count), want);
                expected_results.push_back(want);
            end
            if (i_out_valid && i_out_ready) begin
                got = '{i_status, i_page_index_res, i_pages_avail};
                if (expected_results.size() == 0) begin
                    $error("result transfer with nothing expected");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (got != want) begin
                        if (got.status != want.status)
                            $error("status: expected %0d, actual %0d", want.status, got.status);
                        if (got.page != want.page)
                            $error("page_index_res: expected %0d, actual %0d",
                                   want.page, got.page);
                        if (got.pages_avail != want.pages_avail)
                            $error("pages_avail: expected %0d, actual %0d",
                                   want.pages_avail, got.pages_avail);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
        o_pending <= expected_results.size();
    end
endmodule

FILE: tb/sv/tb.sv
// Top of the buddy page allocator testbench: clock, reset, stimulus and verdict.
// Depends on bpa_pkg, buddy_page_allocator and bpa_checker.
module tb;
    import bpa_pkg::*;

    // Generous bound: clearing pass plus 822 items at worst-case cost.
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASE_ITEMS = 160;
    // Operation code that the block does not know.
    localparam logic [1:0] FUNC_UNKNOWN = 2'd3;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [1:0]        func = FUNC_ADD;
    logic [PAGE_W-1:0] page_index = '0;
    logic [CNT_W-1:0]  page_count = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [1:0]        status;
    logic [PAGE_W-1:0] page_index_res;
    logic [CNT_W-1:0]  pages_avail;
    logic              cfg_we = 1'b0;
    logic [CNT_W-1:0]  cfg_data = '0;
    int                fail_count;
    int                pending;

    int  cycles = 0;
    int  items_sent = 0;
    int  results_seen = 0;
    bit  hold_out = 1'b0;

    // Requests in flight and blocks currently handed out, used to shape frees.
    typedef struct {
        logic [1:0] fn;
        int         cnt;
    } t_request;
    typedef struct {
        int page;
        int cnt;
    } t_block;
    t_request in_flight[$];
    t_block   held_blocks[$];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    buddy_page_allocator u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_func           (func),
        .i_page_index     (page_index),
        .i_page_count     (page_count),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_status         (status),
        .o_page_index_res (page_index_res),
        .o_pages_avail    (pages_avail),
        .i_cfg_we         (cfg_we),
        .i_cfg_data       (cfg_data)
    );

    bpa_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_func           (func),
        .i_page_index     (page_index),
        .i_page_count     (page_count),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_status         (status),
        .i_page_index_res (page_index_res),
        .i_pages_avail    (pages_avail),
        .i_cfg_we         (cfg_we),
        .i_cfg_data       (cfg_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("buddy_page_allocator regression: fail");
            $finish;
        end
    end

    // Receiver: the stall pattern switches between always-ready stretches and
    // stretches with random back-pressure of varying density.
    always @(negedge i_clk) begin
        static int mode_left = 0;
        static int stall_pct = 0;
        if (mode_left == 0) begin
            mode_left = $urandom_range(20, 120);
            stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 80);
        end
        mode_left--;
        out_ready <= !hold_out && ($urandom_range(0, 99) >= stall_pct);
    end

    // Track accepted results so that later frees can return real blocks.
    always @(posedge i_clk) begin
        t_request rq;
        if (out_valid && out_ready && in_flight.size() > 0) begin
            rq = in_flight.pop_front();
            results_seen++;
            if (rq.fn == FUNC_ALLOC && status == ST_DONE)
                held_blocks.push_back('{int'(page_index_res), rq.cnt});
        end
    end

    // Long receiver hold-off in the middle of the run, so the block backs up
    // and stops taking input transfers.
    initial begin
        wait (items_sent >= 300);
        hold_out = 1'b1;
        repeat (400) @(negedge i_clk);
        hold_out = 1'b0;
    end

    // One input transfer: valid rises at a falling edge and stays up, with
    // the payload held, until the block accepts it at a rising edge.
    task automatic send(input logic [1:0] fn, input int idx, input int cnt);
        @(negedge i_clk);
        in_valid   <= 1'b1;
        func       <= fn;
        page_index <= PAGE_W'(idx);
        page_count <= CNT_W'(cnt);
        do @(posedge i_clk); while (!in_ready);
        in_flight.push_back('{fn, cnt});
        items_sent++;
    endtask

    task automatic pause_input(input int n);
        @(negedge i_clk);
        in_valid <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    // Waits until every expected result has come back, then lets the block
    // settle before a register write.
    task automatic drain;
        pause_input(1);
        wait (pending == 0 && in_flight.size() == 0);
        repeat (64) @(negedge i_clk);
    endtask

    task automatic set_page_limit(input int limit);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_data <= CNT_W'(limit);
        @(negedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    // Mostly well-formed traffic: regions that fit, allocations of up to 1024
    // pages and frees of blocks really handed out, plus a share of malformed
    // or stray requests.
    task automatic random_request;
        int pick, cnt, base, sel;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            cnt  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, PAGES)
                                               : $urandom_range(1, 96);
            base = $urandom_range(0, PAGES - cnt);
            if ($urandom_range(0, 19) == 0) base = $urandom_range(PAGES - cnt, PAGES - 1);
            send(FUNC_ADD, base, cnt);
        end else if (pick < 60) begin
            cnt = $urandom_range(1, 1 << $urandom_range(0, 10));
            if ($urandom_range(0, 29) == 0) cnt = $urandom_range(1025, PAGES);
            send(FUNC_ALLOC, 0, cnt);
        end else if (pick < 93) begin
            if (held_blocks.size() > 0 && $urandom_range(0, 9) != 0) begin
                sel = $urandom_range(0, held_blocks.size() - 1);
                send(FUNC_FREE, held_blocks[sel].page, held_blocks[sel].cnt);
                held_blocks.delete(sel);
            end else begin
                send(FUNC_FREE, $urandom_range(0, PAGES - 1), $urandom_range(1, 2048));
            end
        end else begin
            // Noise: unknown operation, zero count, or arbitrary fields.
            sel = $urandom_range(0, 2);
            if (sel == 0) send(FUNC_UNKNOWN, $urandom_range(0, PAGES - 1),
                               $urandom_range(0, PAGES));
            else if (sel == 1) send(2'($urandom_range(0, 2)), $urandom_range(0, PAGES - 1), 0);
            else send(2'($urandom_range(0, 3)), $urandom_range(0, PAGES - 1),
                      $urandom_range(0, (1 << CNT_W) - 1));
        end
    endtask

    initial begin
        int limits[5];
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests at the reset page limit.
        send(FUNC_ALLOC, 0, 1);             // nothing free yet
        send(FUNC_ADD, 0, 0);               // zero count
        send(FUNC_UNKNOWN, PAGES - 1, PAGES); // unknown operation
        send(FUNC_ADD, 16000, 1000);        // region past the end
        send(FUNC_ADD, 0, PAGES);           // whole memory as top-order blocks
        send(FUNC_ALLOC, 0, 1);             // split all the way down
        send(FUNC_ALLOC, 0, 1024);
        send(FUNC_ALLOC, 0, 1025);          // order too large
        send(FUNC_ALLOC, 0, PAGES);
        send(FUNC_FREE, 0, 0);
        send(FUNC_FREE, 0, 2048);           // order too large
        send(FUNC_FREE, PAGES - 1, 1);      // last page
        send(FUNC_FREE, 0, 1);              // no merge, its buddy is not a free block
        send(FUNC_ALLOC, 0, 3);
        send(FUNC_ALLOC, 0, 300);
        send(FUNC_ADD, PAGES - 1, 1);
        send(FUNC_ADD, 5, 1000);            // unaligned region, many sizes
        drain();

        // Phases with different page limits, including both extremes.
        limits = '{1, 12288, $urandom_range(2, PAGES - 1), 4097, PAGES};
        foreach (limits[ph]) begin
            set_page_limit(limits[ph]);
            send(FUNC_ADD, $urandom_range(0, 15) * 1024, 1024);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                random_request();
                if ($urandom_range(0, 5) == 0) pause_input($urandom_range(1, 12));
            end
            drain();
        end

        $display("covered %0d requests and %0d results over 6 page-limit settings",
                 items_sent, results_seen);
        if (fail_count == 0) begin
            $display("buddy_page_allocator regression: pass");
        end else begin
            $display("buddy_page_allocator regression: fail");
        end
        $finish;
    end
endmodule

FILE: sim.f
+incdir+src
src/bpa_pkg.sv
src/bpa_page_mem.sv
src/buddy_page_allocator.sv
tb/sv/bpa_checker.sv
tb/sv/tb.sv
